/* sv/ddt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddt_pkg
// Shared types and status codes for the digest deduplication table.
// ----------------------------------------------------------------------------
package ddt_pkg;

  localparam logic [1:0] ST_NEW  = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [63:0] digest_a;
    logic [63:0] digest_b;
    logic [31:0] digest_c;
    logic [63:0] size;
    logic [63:0] offset;
  } entry_t;

endpackage
`default_nettype wire

/* sv/digest_dedup_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// digest_dedup_table
// Bucketed lookup-or-insert table of 160-bit digests with a duplicate count.
// ----------------------------------------------------------------------------
// Channel  Handshake        Fields
// request  start / busy     hash_key, digest_word0..2, object_size, object_offset
// result   done (strobe)    status, result_offset, duplicate_total
//
// Each request is handled by the engine as a bucket row read, then compare and
// write-back. The result is registered at the end of the compare step.
// After reset a clearing pass over all NUM_BUCKETS buckets holds busy high.
// A two-entry queue absorbs requests while the engine works; busy rises
// when it is full. Results cannot be stalled.
// ----------------------------------------------------------------------------
module digest_dedup_table #(
  parameter int NUM_BUCKETS = 1024,
  parameter int NUM_WAYS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] hash_key,
  input  wire logic [63:0] digest_word0,
  input  wire logic [63:0] digest_word1,
  input  wire logic [31:0] digest_word2,
  input  wire logic [63:0] object_size,
  input  wire logic [63:0] object_offset,
  output logic             done,
  output logic [1:0]       status,
  output logic [63:0]      result_offset,
  output logic [31:0]      duplicate_total
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  ddt_pkg::entry_t in_entry;
  ddt_pkg::entry_t q_entry;
  logic [BW-1:0]   q_bucket;
  logic            q_valid;
  logic            full;
  logic            pop;
  logic            clearing;

  assign in_entry = '{digest_a: digest_word0, digest_b: digest_word1,
                      digest_c: digest_word2, size: object_size,
                      offset: object_offset};
  assign busy = full || clearing;

  ddt_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk(clk), .rst(rst), .push(start && !busy), .hash_key(hash_key),
    .push_entry(in_entry), .full(full), .q_valid(q_valid),
    .q_bucket(q_bucket), .q_entry(q_entry), .pop(pop)
  );

  ddt_engine #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_WAYS(NUM_WAYS)) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_bucket(q_bucket),
    .q_entry(q_entry), .pop(pop), .clearing(clearing), .done(done),
    .status(status), .result_offset(result_offset),
    .duplicate_total(duplicate_total)
  );

endmodule
`default_nettype wire

/* sv/ddt_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddt_front
// Takes requests and folds the key into a small partial residue on entry.
// Holds them in a two-entry queue and finishes the reduction to a bucket
// number at the queue head for the table engine.
// ----------------------------------------------------------------------------
module ddt_front #(
  parameter int NUM_BUCKETS = 1024,
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire logic [63:0]    hash_key,
  input  wire ddt_pkg::entry_t push_entry,
  output logic                full,
  output logic                q_valid,
  output logic [BW-1:0]       q_bucket,
  output ddt_pkg::entry_t     q_entry,
  input  wire logic           pop
);

  localparam int SW = 20;
  localparam logic [SW-1:0] FOLD1 = SW'(NUM_BUCKETS);
  localparam logic [SW-1:0] FOLD2 = SW'(2 * NUM_BUCKETS);
  localparam logic [SW-1:0] FOLD4 = SW'(4 * NUM_BUCKETS);

  // Weight of key byte j modulo the bucket count, that is 256^j mod N.
  function automatic logic [63:0] byte_weight(input int j);
    logic [63:0] p;
    p = 64'd1 % 64'(NUM_BUCKETS);
    for (int i = 0; i < j; i++) p = (p * 64'd256) % 64'(NUM_BUCKETS);
    return p;
  endfunction

  logic [BW-1:0]   byte_res [8][256];
  logic [SW-1:0]   part [8];
  logic [SW-1:0]   key_sum;
  logic [SW-1:0]   red;
  logic [SW-1:0]   sum [2];
  ddt_pkg::entry_t ent [2];
  logic            rd_ptr;
  logic            wr_ptr;
  logic [1:0]      count;

  // Each key byte maps through a constant table to its residue; the sum of
  // the eight residues stays below eight times the bucket count.
  for (genvar j = 0; j < 8; j++) begin : g_byte
    for (genvar b = 0; b < 256; b++) begin : g_val
      localparam logic [BW-1:0] RES =
        BW'((64'(b) * byte_weight(j)) % 64'(NUM_BUCKETS));
      assign byte_res[j][b] = RES;
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) part[j] = SW'(byte_res[j][hash_key[8*j +: 8]]);
    key_sum = ((part[0] + part[1]) + (part[2] + part[3])) +
              ((part[4] + part[5]) + (part[6] + part[7]));
  end

  always_comb begin
    red = sum[rd_ptr];
    if (red >= FOLD4) red = red - FOLD4;
    if (red >= FOLD2) red = red - FOLD2;
    if (red >= FOLD1) red = red - FOLD1;
  end

  assign full     = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_bucket = red[BW-1:0];
  assign q_entry  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      sum[wr_ptr] <= key_sum;
      ent[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* sv/ddt_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddt_engine
// Clears the table after reset, then for each queued request reads one
// bucket row, compares all ways, and writes back the row on an insert.
// ----------------------------------------------------------------------------
module ddt_engine #(
  parameter int NUM_BUCKETS = 1024,
  parameter int NUM_WAYS    = 8,
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire logic [BW-1:0]   q_bucket,
  input  wire ddt_pkg::entry_t q_entry,
  output logic                 pop,
  output logic                 clearing,
  output logic                 done,
  output logic [1:0]           status,
  output logic [63:0]          result_offset,
  output logic [31:0]          duplicate_total
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_CMP   = 3'b100
  } state_t;

  state_t state, state_next;

  ddt_pkg::entry_t     data_mem  [NUM_BUCKETS][NUM_WAYS];
  logic [NUM_WAYS-1:0] valid_mem [NUM_BUCKETS];

  ddt_pkg::entry_t     rd_row [NUM_WAYS];
  logic [NUM_WAYS-1:0] rd_valid;
  logic [BW-1:0]       cur_bucket;
  ddt_pkg::entry_t     cur_entry;
  logic [BW-1:0]       clr_addr;

  logic [NUM_WAYS-1:0] hit;
  logic                any_hit;
  logic [63:0]         hit_offset;
  logic                have_free;
  logic [NUM_WAYS-1:0] free_onehot;

  always_comb begin
    any_hit = 1'b0;
    hit_offset = cur_entry.offset;
    have_free = 1'b0;
    free_onehot = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      hit[w] = rd_valid[w] && (rd_row[w] == {cur_entry.digest_a, cur_entry.digest_b,
               cur_entry.digest_c, cur_entry.size, rd_row[w].offset});
      if (hit[w] && !any_hit) begin
        any_hit = 1'b1;
        hit_offset = rd_row[w].offset;
      end
      if (!rd_valid[w] && !have_free) begin
        have_free = 1'b1;
        free_onehot[w] = 1'b1;
      end
    end
  end

  assign pop      = (state == S_IDLE) && q_valid;
  assign clearing = (state == S_CLEAR);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == BW'(NUM_BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (q_valid) state_next = S_CMP;
      S_CMP:   state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_row     <= data_mem[q_bucket];
      cur_bucket <= q_bucket;
      cur_entry  <= q_entry;
    end
    if (state == S_CMP && !any_hit) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (free_onehot[w]) data_mem[cur_bucket][w] <= cur_entry;
      end
    end
    result_offset <= any_hit ? hit_offset : cur_entry.offset;
    status <= any_hit ? ddt_pkg::ST_DUP : (have_free ? ddt_pkg::ST_NEW : ddt_pkg::ST_FULL);
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) valid_mem[clr_addr] <= '0;
    else if (state == S_CMP && !any_hit) valid_mem[cur_bucket] <= rd_valid | free_onehot;
    if (pop) rd_valid <= valid_mem[q_bucket];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      done            <= 1'b0;
      duplicate_total <= '0;
    end else begin
      state <= state_next;
      done  <= (state == S_CMP);
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_CMP && any_hit && duplicate_total != 32'hFFFF_FFFF)
        duplicate_total <= duplicate_total + 32'd1;
    end
  end

endmodule
`default_nettype wire

/* bench/ddt_checker.sv */
// ----------------------------------------------------------------------------
// ddt_checker
// Watches the request and result channels of the deduplication table. It
// keeps its own copy of the table, works out the response to each accepted
// request and compares every result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module ddt_checker #(
  parameter int NUM_BUCKETS = 1024,
  parameter int NUM_WAYS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [63:0] hash_key,
  input  wire logic [63:0] digest_word0,
  input  wire logic [63:0] digest_word1,
  input  wire logic [31:0] digest_word2,
  input  wire logic [63:0] object_size,
  input  wire logic [63:0] object_offset,
  input  wire logic        done,
  input  wire logic [1:0]  status,
  input  wire logic [63:0] result_offset,
  input  wire logic [31:0] duplicate_total,
  output int               fail_count,
  output int               pending,
  output int               new_seen,
  output int               dup_seen,
  output int               full_seen
);

  localparam int DEPTH = NUM_BUCKETS * NUM_WAYS;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] offset;
    logic [31:0] total;
  } response_t;

  logic             slot_used [DEPTH];
  ddt_pkg::entry_t  slot_entry [DEPTH];
  logic [31:0]      dup_tally;
  response_t        awaited [$];

  task automatic lookup_or_insert(output response_t resp);
    int  base;
    int  free_slot;
    bit  found_free;
    int  idx;
    resp.status = ddt_pkg::ST_FULL;
    resp.offset = object_offset;
    found_free  = 0;
    free_slot   = 0;
    base = int'(hash_key % 64'(NUM_BUCKETS)) * NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++) begin
      idx = base + w;
      if (slot_used[idx]) begin
        if (resp.status != ddt_pkg::ST_DUP && slot_entry[idx].size == object_size &&
            slot_entry[idx].digest_a == digest_word0 &&
            slot_entry[idx].digest_b == digest_word1 &&
            slot_entry[idx].digest_c == digest_word2) begin
          resp.status = ddt_pkg::ST_DUP;
          resp.offset = slot_entry[idx].offset;
        end
      end else if (!found_free) begin
        found_free = 1;
        free_slot  = idx;
      end
    end
    if (resp.status == ddt_pkg::ST_DUP) begin
      if (dup_tally != 32'hFFFF_FFFF) dup_tally = dup_tally + 32'd1;
    end else if (found_free) begin
      slot_used[free_slot]  = 1'b1;
      slot_entry[free_slot] = '{digest_word0, digest_word1, digest_word2,
                                object_size, object_offset};
      resp.status = ddt_pkg::ST_NEW;
    end
    resp.total = dup_tally;
  endtask

  always @(posedge clk) begin
    response_t want;
    response_t got;
    if (rst) begin
      dup_tally  = '0;
      fail_count = 0;
      new_seen   = 0;
      dup_seen   = 0;
      full_seen  = 0;
      for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
      awaited.delete();
      pending = 0;
    end else begin
      if (done) begin
        got = '{status, result_offset, duplicate_total};
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result status=%0d offset=%h total=%0d",
                   $time, status, result_offset, duplicate_total);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     got.status);
            fail_count++;
          end
          if (got.offset != want.offset) begin
            $display("%0t: result_offset expected %h actual %h", $time,
                     want.offset, got.offset);
            fail_count++;
          end
          if (got.total != want.total) begin
            $display("%0t: duplicate_total expected %0d actual %0d", $time,
                     want.total, got.total);
            fail_count++;
          end
          case (want.status)
            ddt_pkg::ST_NEW: new_seen++;
            ddt_pkg::ST_DUP: dup_seen++;
            default:         full_seen++;
          endcase
        end
      end
      if (start && !busy) begin
        lookup_or_insert(want);
        awaited.push_back(want);
      end
      pending = awaited.size();
    end
  end
endmodule

/* bench/tb_digest_dedup_table.sv */
// ----------------------------------------------------------------------------
// tb_digest_dedup_table
// Drives directed and random requests into the deduplication table: fresh
// objects crowded into a few buckets, repeats, near-misses on size and digest,
// and full buckets. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_digest_dedup_table;

  localparam int NUM_BUCKETS = 1024;
  localparam int NUM_WAYS    = 8;
  localparam int RANDOM_REQS = 1100;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] d0;
    logic [63:0] d1;
    logic [31:0] d2;
    logic [63:0] size;
    logic [63:0] offset;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] hash_key = '0;
  logic [63:0] digest_word0 = '0;
  logic [63:0] digest_word1 = '0;
  logic [31:0] digest_word2 = '0;
  logic [63:0] object_size = '0;
  logic [63:0] object_offset = '0;
  logic        done;
  logic [1:0]  status;
  logic [63:0] result_offset;
  logic [31:0] duplicate_total;
  int          fail_count, pending, new_seen, dup_seen, full_seen;
  int          quiet_cycles = 0;
  bit          no_idle = 0;
  request_t    history [$];

  always #5 clk = ~clk;

  digest_dedup_table #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_WAYS(NUM_WAYS)) u_dut (
    .clk, .rst, .start, .busy, .hash_key, .digest_word0, .digest_word1,
    .digest_word2, .object_size, .object_offset, .done, .status,
    .result_offset, .duplicate_total
  );

  ddt_checker #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_WAYS(NUM_WAYS)) u_checker (
    .clk, .rst, .start, .busy, .hash_key, .digest_word0, .digest_word1,
    .digest_word2, .object_size, .object_offset, .done, .status,
    .result_offset, .duplicate_total, .fail_count, .pending, .new_seen,
    .dup_seen, .full_seen
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("** digest_dedup_table: FAILED **");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] key_for(int bucket);
    logic [63:0] k;
    k = rand64();
    return k - (k % 64'(NUM_BUCKETS)) + 64'(bucket);
  endfunction

  task automatic send(request_t r);
    if (!no_idle && $urandom_range(99) < 11) begin
      start = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start         = 1'b1;
    hash_key      = r.key;
    digest_word0  = r.d0;
    digest_word1  = r.d1;
    digest_word2  = r.d2;
    object_size   = r.size;
    object_offset = r.offset;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
    history.push_back(r);
    if (history.size() > 64) void'(history.pop_front());
  endtask

  function automatic request_t fresh(int bucket);
    request_t r;
    r = '{key_for(bucket), rand64(), rand64(), $urandom(), rand64(), rand64()};
    if ($urandom_range(9) == 0) r.size = 64'($urandom_range(3));
    return r;
  endfunction

  initial begin
    request_t r;
    request_t keep;
    int pick;
    int settle;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    r = '{64'd0, 64'd0, 64'd0, 32'd0, 64'd0, 64'd0};
    send(r);
    send(r);
    r = '{'1, '1, '1, '1, '1, '1};
    send(r);
    send(r);
    keep = fresh(5);
    send(keep);
    r = keep;
    r.size = ~keep.size;
    send(r);
    r = keep;
    r.d2 = ~keep.d2;
    send(r);
    for (int i = 0; i < 6; i++) send(fresh(5));
    r = fresh(5);
    send(r);
    send(keep);
    r.offset = rand64();
    send(r);
    r = keep;
    r.key = key_for(6);
    send(r);
    send(keep);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      no_idle = (i >= 400 && i < 600);
      pick = $urandom_range(99);
      if (pick < 35 && history.size() > 0) begin
        r = history[$urandom_range(history.size() - 1)];
        r.offset = rand64();
      end else if (pick < 45 && history.size() > 0) begin
        r = history[$urandom_range(history.size() - 1)];
        r.size = r.size ^ (64'd1 << $urandom_range(63));
      end else if (pick < 55 && history.size() > 0) begin
        r = history[$urandom_range(history.size() - 1)];
        case ($urandom_range(2))
          0:       r.d0 = r.d0 ^ (64'd1 << $urandom_range(63));
          1:       r.d1 = r.d1 ^ (64'd1 << $urandom_range(63));
          default: r.d2 = r.d2 ^ (32'd1 << $urandom_range(31));
        endcase
      end else if (pick < 90) begin
        r = fresh($urandom_range(1) ? $urandom_range(23) : NUM_BUCKETS - 1);
      end else begin
        r = '{rand64(), rand64(), rand64(), $urandom(), rand64(), rand64()};
      end
      send(r);
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    settle = 0;
    while (settle < 20) begin
      @(negedge clk);
      settle++;
    end

    $display("Run covered %0d new, %0d duplicate and %0d bucket-full results.",
             new_seen, dup_seen, full_seen);
    if (fail_count == 0) begin
      $display("** digest_dedup_table: PASSED **");
    end else begin
      $display("** digest_dedup_table: FAILED **");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/ddt_pkg.sv
sv/ddt_front.sv
sv/ddt_engine.sv
sv/digest_dedup_table.sv
bench/ddt_checker.sv
bench/tb_digest_dedup_table.sv
